### rtl/core/vapf_pkg.sv
// shared types, constants and axis order table for the volume permute and flip core
package vapf_pkg;

    localparam int MAX_EXTENT   = 1024;
    localparam int SAMPLE_BITS  = 32;
    localparam int EXT_W        = 11;
    localparam int CNT_W        = $clog2(MAX_EXTENT);
    localparam int STRIDE_W     = 2 * CNT_W + 1;
    localparam int PROD_W       = CNT_W + STRIDE_W;
    localparam int SUM_W        = PROD_W + 2;
    localparam int IDX_W        = 30;
    localparam int ORDER_W      = 3;
    localparam int NUM_AXES     = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = EXT_W;
    localparam int IN_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((IDX_W + SAMPLE_BITS + 7) / 8) * 8;

    // stored dimension slots: slow, mid, fast
    localparam int DIM_SLOW = 0;
    localparam int DIM_MID  = 1;
    localparam int DIM_FAST = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTENT_SLOW  = 3'd0,
        REG_EXTENT_MID   = 3'd1,
        REG_EXTENT_FAST  = 3'd2,
        REG_SOURCE_ORDER = 3'd3,
        REG_DEST_ORDER   = 3'd4,
        REG_FLIP_X       = 3'd5,
        REG_FLIP_Y       = 3'd6,
        REG_FLIP_Z       = 3'd7
    } t_cfg_reg;

    typedef enum logic [ORDER_W-1:0] {
        ORDER_XYZ = 3'd0,
        ORDER_XZY = 3'd1,
        ORDER_YXZ = 3'd2,
        ORDER_YZX = 3'd3,
        ORDER_ZXY = 3'd4,
        ORDER_ZYX = 3'd5
    } t_order;

    typedef logic [1:0] t_axis;
    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    typedef struct packed {
        logic [NUM_AXES-1:0][EXT_W-1:0]    ext_stored;
        logic [NUM_AXES-1:0][EXT_W-1:0]    size;
        logic [ORDER_W-1:0]                src_order;
        logic [NUM_AXES-1:0]               flip;
        logic [NUM_AXES-1:0][STRIDE_W-1:0] stride;
    } t_cfg_view;

    typedef struct packed {
        logic [NUM_AXES-1:0][CNT_W-1:0] coord;
        logic [SAMPLE_BITS-1:0]         value;
        logic                           last;
    } t_stage_a;

    // axis held at place k of an order, fastest first; unused codes act as xyz
    function automatic t_axis order_axis(input logic [ORDER_W-1:0] order, input logic [1:0] k);
        t_axis a0;
        t_axis a1;
        t_axis a2;
        t_axis res;
        case (t_order'(order))
            ORDER_XZY: begin a0 = AXIS_X; a1 = AXIS_Z; a2 = AXIS_Y; end
            ORDER_YXZ: begin a0 = AXIS_Y; a1 = AXIS_X; a2 = AXIS_Z; end
            ORDER_YZX: begin a0 = AXIS_Y; a1 = AXIS_Z; a2 = AXIS_X; end
            ORDER_ZXY: begin a0 = AXIS_Z; a1 = AXIS_X; a2 = AXIS_Y; end
            ORDER_ZYX: begin a0 = AXIS_Z; a1 = AXIS_Y; a2 = AXIS_X; end
            default:   begin a0 = AXIS_X; a1 = AXIS_Y; a2 = AXIS_Z; end
        endcase
        case (k)
            2'd0:    res = a0;
            2'd1:    res = a1;
            default: res = a2;
        endcase
        return res;
    endfunction

endpackage

### rtl/core/vapf_cfg.sv
// configuration registers, effective extents, logical sizes and destination strides
module vapf_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vapf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vapf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output vapf_pkg::t_cfg_view             o_cfg
);
    import vapf_pkg::*;

    logic [NUM_AXES-1:0][EXT_W-1:0]    r_extent;
    logic [ORDER_W-1:0]                r_src_order;
    logic [ORDER_W-1:0]                r_dst_order;
    logic [NUM_AXES-1:0]               r_flip;
    logic [NUM_AXES-1:0][STRIDE_W-1:0] r_stride;
    logic [NUM_AXES-1:0][STRIDE_W-1:0] n_stride;

    logic [NUM_AXES-1:0][EXT_W-1:0] w_eff;
    logic [NUM_AXES-1:0][EXT_W-1:0] w_size;
    logic [2*EXT_W-1:0]             w_plane;
    t_axis                          w_d0;
    t_axis                          w_d1;
    t_axis                          w_d2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extent    <= {NUM_AXES{EXT_W'(1)}};
            r_src_order <= '0;
            r_dst_order <= '0;
            r_flip      <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_EXTENT_SLOW:  r_extent[DIM_SLOW] <= i_cfg_data[EXT_W-1:0];
                REG_EXTENT_MID:   r_extent[DIM_MID]  <= i_cfg_data[EXT_W-1:0];
                REG_EXTENT_FAST:  r_extent[DIM_FAST] <= i_cfg_data[EXT_W-1:0];
                REG_SOURCE_ORDER: r_src_order        <= i_cfg_data[ORDER_W-1:0];
                REG_DEST_ORDER:   r_dst_order        <= i_cfg_data[ORDER_W-1:0];
                REG_FLIP_X:       r_flip[AXIS_X]     <= i_cfg_data[0];
                REG_FLIP_Y:       r_flip[AXIS_Y]     <= i_cfg_data[0];
                REG_FLIP_Z:       r_flip[AXIS_Z]     <= i_cfg_data[0];
            endcase
        end
    end

    // zero acts as one, anything above the maximum saturates
    always_comb begin
        for (int s = 0; s < NUM_AXES; s++) begin
            if (r_extent[s] == '0) begin
                w_eff[s] = EXT_W'(1);
            end else if (r_extent[s] > EXT_W'(MAX_EXTENT)) begin
                w_eff[s] = EXT_W'(MAX_EXTENT);
            end else begin
                w_eff[s] = r_extent[s];
            end
        end
    end

    // place k of the source order (fastest first) is stored dimension 2-k
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_size[a] = EXT_W'(1);
            for (int k = 0; k < NUM_AXES; k++) begin
                if (order_axis(r_src_order, 2'(k)) == t_axis'(a)) begin
                    w_size[a] = w_eff[NUM_AXES-1-k];
                end
            end
        end
    end

    assign w_d0    = order_axis(r_dst_order, 2'd0);
    assign w_d1    = order_axis(r_dst_order, 2'd1);
    assign w_d2    = order_axis(r_dst_order, 2'd2);
    assign w_plane = w_size[w_d0] * w_size[w_d1];

    always_comb begin
        n_stride       = '0;
        n_stride[w_d0] = STRIDE_W'(1);
        n_stride[w_d1] = STRIDE_W'(w_size[w_d0]);
        n_stride[w_d2] = w_plane[STRIDE_W-1:0];
    end

    // strides follow the registers in the next cycle, ahead of the product stage
    always_ff @(posedge i_clk) begin
        r_stride <= n_stride;
    end

    assign o_cfg.ext_stored = w_eff;
    assign o_cfg.size       = w_size;
    assign o_cfg.src_order  = r_src_order;
    assign o_cfg.flip       = r_flip;
    assign o_cfg.stride     = r_stride;

endmodule

### rtl/core/vapf_map.sv
// position counters, axis remap and flip into the first pipeline register
module vapf_map (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vapf_pkg::t_cfg_view              i_cfg,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [vapf_pkg::SAMPLE_BITS-1:0] i_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output vapf_pkg::t_stage_a               o_stage
);
    import vapf_pkg::*;

    logic [NUM_AXES-1:0][CNT_W-1:0] r_count;
    logic                           r_valid;
    t_stage_a                       r_stage;

    logic                           w_accept;
    logic [NUM_AXES-1:0][CNT_W-1:0] w_pos;
    logic [NUM_AXES-1:0]            w_last;
    logic                           w_last_all;
    logic [NUM_AXES-1:0][EXT_W-1:0] w_raw;
    logic [NUM_AXES-1:0][CNT_W-1:0] w_coord;
    logic [EXT_W-1:0]               w_flip_val [NUM_AXES];

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // a counter past its extent maps to the last position and counts as last
    always_comb begin
        for (int s = 0; s < NUM_AXES; s++) begin
            w_last[s] = {1'b0, r_count[s]} >= (i_cfg.ext_stored[s] - EXT_W'(1));
            if ({1'b0, r_count[s]} >= i_cfg.ext_stored[s]) begin
                w_pos[s] = CNT_W'(i_cfg.ext_stored[s] - EXT_W'(1));
            end else begin
                w_pos[s] = r_count[s];
            end
        end
    end

    assign w_last_all = &w_last;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_raw[a] = '0;
            for (int k = 0; k < NUM_AXES; k++) begin
                if (order_axis(i_cfg.src_order, 2'(k)) == t_axis'(a)) begin
                    w_raw[a] = EXT_W'(w_pos[NUM_AXES-1-k]);
                end
            end
            w_flip_val[a] = i_cfg.size[a] - EXT_W'(1) - w_raw[a];
            w_coord[a]    = i_cfg.flip[a] ? w_flip_val[a][CNT_W-1:0] : w_raw[a][CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (w_accept) begin
                // fast wraps into mid, mid into slow
                if (!w_last[DIM_FAST]) begin
                    r_count[DIM_FAST] <= r_count[DIM_FAST] + CNT_W'(1);
                end else begin
                    r_count[DIM_FAST] <= '0;
                    if (!w_last[DIM_MID]) begin
                        r_count[DIM_MID] <= r_count[DIM_MID] + CNT_W'(1);
                    end else begin
                        r_count[DIM_MID] <= '0;
                        if (!w_last[DIM_SLOW]) begin
                            r_count[DIM_SLOW] <= r_count[DIM_SLOW] + CNT_W'(1);
                        end else begin
                            r_count[DIM_SLOW] <= '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stage.coord <= w_coord;
            r_stage.value <= i_value;
            r_stage.last  <= w_last_all;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

    a_wrap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last_all) |=> (r_count == '0))
        else $error("counters not cleared after the final element");

    a_fast_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_last[DIM_FAST])
        |=> (r_count[DIM_FAST] == $past(r_count[DIM_FAST]) + CNT_W'(1)))
        else $error("fast counter did not advance by one");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("counters moved without an accepted request");

endmodule

### rtl/core/vapf_index.sv
// stride products and index sum, second pipeline register and output register
module vapf_index (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic [vapf_pkg::NUM_AXES-1:0][vapf_pkg::STRIDE_W-1:0] i_stride,
    input  logic                                                  i_valid,
    output logic                                                  o_ready,
    input  vapf_pkg::t_stage_a                                    i_stage,
    output logic                                                  o_valid,
    input  logic                                                  i_ready,
    output logic [vapf_pkg::IDX_W-1:0]                            o_index,
    output logic [vapf_pkg::SAMPLE_BITS-1:0]                      o_value,
    output logic                                                  o_last
);
    import vapf_pkg::*;

    logic                          r_b_valid;
    logic [NUM_AXES-1:0][PROD_W-1:0] r_b_prod;
    logic [SAMPLE_BITS-1:0]        r_b_value;
    logic                          r_b_last;

    logic                          r_c_valid;
    logic [IDX_W-1:0]              r_c_index;
    logic [SAMPLE_BITS-1:0]        r_c_value;
    logic                          r_c_last;

    logic                          w_c_ready;
    logic                          w_b_ready;
    logic                          w_b_load;
    logic                          w_c_load;
    logic [SUM_W-1:0]              w_sum;

    assign w_c_ready = !r_c_valid || i_ready;
    assign w_b_ready = !r_b_valid || w_c_ready;
    assign o_ready   = w_b_ready;
    assign w_b_load  = i_valid && w_b_ready;
    assign w_c_load  = r_b_valid && w_c_ready;

    assign w_sum = SUM_W'(r_b_prod[AXIS_X]) + SUM_W'(r_b_prod[AXIS_Y])
                 + SUM_W'(r_b_prod[AXIS_Z]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_b_load) begin
                r_b_valid <= 1'b1;
            end else if (w_c_ready) begin
                r_b_valid <= 1'b0;
            end
            if (w_c_load) begin
                r_c_valid <= 1'b1;
            end else if (i_ready) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_load) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_b_prod[a] <= i_stage.coord[a] * i_stride[a];
            end
            r_b_value <= i_stage.value;
            r_b_last  <= i_stage.last;
        end
        if (w_c_load) begin
            r_c_index <= w_sum[IDX_W-1:0];
            r_c_value <= r_b_value;
            r_c_last  <= r_b_last;
        end
    end

    assign o_valid = r_c_valid;
    assign o_index = r_c_index;
    assign o_value = r_c_value;
    assign o_last  = r_c_last;

endmodule

### rtl/core/volume_axis_permute_flip_core.sv
// top level of the volume permute and flip scatter address generator
//
// usage
//   samples enter on the s_axis channel one per request in source storage order,
//   fastest stored dimension first; each one leaves on m_axis with the linear
//   index it takes in the destination volume, the sample unchanged, and tlast
//   set on the final element of the volume, after which the counters wrap
//   the cfg channel writes the eight registers by index; it is always ready and
//   is meant to be used only while no request is in flight
// throughput and pipeline
//   one request per cycle while the receiver takes results; a request taken passes
//   the remap register, the stride product register and the output register
//   before its result is valid on m_axis
//   strides are rebuilt from the registers every cycle, in the cycle after a write
// reset
//   synchronous, active low; extents return to one, orders to xyz, flips off,
//   position counters to zero and the pipeline empties
// stalls
//   a stalled receiver holds the output register; the earlier stages keep
//   filling until full, then s_axis tready drops, so at most three requests are
//   in flight: the one held at the output and two behind it
module volume_axis_permute_flip_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample input, tdata: element_value
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [vapf_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // result output, tdata: dest_index, moved_value, zero fill; tlast: volume_end
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [vapf_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vapf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vapf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import vapf_pkg::*;

    t_cfg_view              w_cfg;
    t_stage_a               w_stage;
    logic                   w_a_valid;
    logic                   w_a_ready;
    logic [IDX_W-1:0]       w_index;
    logic [SAMPLE_BITS-1:0] w_value;

    // register file and derived geometry
    vapf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // counters and remap, first register
    vapf_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_value (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_valid (w_a_valid),
        .i_ready (w_a_ready),
        .o_stage (w_stage)
    );

    // products and sum, product register and output register
    vapf_index u_index (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stride (w_cfg.stride),
        .i_valid  (w_a_valid),
        .o_ready  (w_a_ready),
        .i_stage  (w_stage),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_index  (w_index),
        .o_value  (w_value),
        .o_last   (o_m_axis_tlast)
    );

    // index in the low bits, sample above it, zero fill to whole bytes
    assign o_m_axis_tdata = OUT_TDATA_W'({w_value, w_index});

    a_stall_needs_full_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled while the output register is empty");

endmodule

### bench/volume_axis_permute_flip_core_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the volume permute and flip scatter address core
module volume_axis_permute_flip_core_tb;
    import vapf_pkg::*;

    localparam int     HALF_PERIOD    = 5;
    localparam int     RESET_CYCLES   = 12;
    localparam longint CYCLE_LIMIT    = 1_000_000;
    localparam int     RANDOM_SAMPLES = 1560;
    localparam int     REPORT_MAX     = 10;

    // one predicted scatter result, fields as they leave on m_axis
    typedef struct packed {
        logic [IDX_W-1:0]       index;
        logic [SAMPLE_BITS-1:0] value;
        logic                   last;
    } t_scatter;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   rx_ready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor copy of the registers (extents by stored dimension, flips by axis)
    logic [EXT_W-1:0]   extent_reg [NUM_AXES] = '{1, 1, 1};
    logic [ORDER_W-1:0] src_order_reg         = ORDER_XYZ;
    logic [ORDER_W-1:0] dst_order_reg         = ORDER_XYZ;
    logic               flip_reg [NUM_AXES]   = '{0, 0, 0};
    // predictor copy of the position counters, by stored dimension
    logic [CNT_W-1:0]   pos_count [NUM_AXES]  = '{0, 0, 0};

    t_scatter pending_scatter [$];

    int     samples_sent    = 0;
    int     results_checked = 0;
    int     volume_ends     = 0;
    int     cfg_writes      = 0;
    int     mismatches      = 0;
    longint cycle_count     = 0;
    int     hold_left       = 0;  // long receiver hold-off, in cycles
    int     stall_left      = 0;  // short random receiver stall
    bit     steady          = 1'b0;  // no idling on either side
    bit     tx_held         = 1'b0;  // s_tvalid left high after the last request

    volume_axis_permute_flip_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog on the whole run
    initial begin
        wait (cycle_count > CYCLE_LIMIT);
        $display("volume_axis_permute_flip_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // zero reads as one, anything past the maximum saturates
    function automatic int unsigned effective_extent(logic [EXT_W-1:0] r);
        if (r == '0)
            return 1;
        if (r > MAX_EXTENT)
            return MAX_EXTENT;
        return 32'(r);
    endfunction

    // logical axis at place k of an order, fastest first; spare codes act as xyz
    function automatic int axis_of(logic [ORDER_W-1:0] order, int k);
        int seq [3];
        case (order)
            ORDER_XZY: seq = '{AXIS_X, AXIS_Z, AXIS_Y};
            ORDER_YXZ: seq = '{AXIS_Y, AXIS_X, AXIS_Z};
            ORDER_YZX: seq = '{AXIS_Y, AXIS_Z, AXIS_X};
            ORDER_ZXY: seq = '{AXIS_Z, AXIS_X, AXIS_Y};
            ORDER_ZYX: seq = '{AXIS_Z, AXIS_Y, AXIS_X};
            default:   seq = '{AXIS_X, AXIS_Y, AXIS_Z};
        endcase
        return seq[k];
    endfunction

    // destination of the sample at the current position, then step the counters
    function automatic t_scatter place_element(logic [SAMPLE_BITS-1:0] sample);
        int unsigned     ext [3];
        int unsigned     pos [3];
        int unsigned     coord [3];
        int unsigned     size [3];
        longint unsigned stride [3];
        longint unsigned acc;
        longint unsigned idx;
        bit              at_end [3];
        int              a;
        t_scatter        r;
        for (int d = 0; d < NUM_AXES; d++) begin
            ext[d] = effective_extent(extent_reg[d]);
            // a counter left past a shrunk extent maps as its last position
            pos[d] = (pos_count[d] >= ext[d]) ? ext[d] - 1 : pos_count[d];
            at_end[d] = (pos_count[d] >= ext[d] - 1);
        end
        // fastest source axis lives in the fast stored dimension
        for (int k = 0; k < NUM_AXES; k++) begin
            a = axis_of(src_order_reg, k);
            coord[a] = pos[DIM_FAST - k];
            size[a] = ext[DIM_FAST - k];
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            if (flip_reg[k])
                coord[k] = size[k] - 1 - coord[k];
        end
        acc = 1;
        for (int k = 0; k < NUM_AXES; k++) begin
            a = axis_of(dst_order_reg, k);
            stride[a] = acc;
            acc = acc * size[a];
        end
        idx = coord[AXIS_X] * stride[AXIS_X] + coord[AXIS_Y] * stride[AXIS_Y]
            + coord[AXIS_Z] * stride[AXIS_Z];
        r.index = idx[IDX_W-1:0];
        r.value = sample;
        r.last  = at_end[DIM_SLOW] && at_end[DIM_MID] && at_end[DIM_FAST];
        // odometer step, wrapping after the last element of the volume
        if (!at_end[DIM_FAST]) begin
            pos_count[DIM_FAST] = pos_count[DIM_FAST] + 1'b1;
        end else begin
            pos_count[DIM_FAST] = '0;
            if (!at_end[DIM_MID]) begin
                pos_count[DIM_MID] = pos_count[DIM_MID] + 1'b1;
            end else begin
                pos_count[DIM_MID] = '0;
                if (!at_end[DIM_SLOW])
                    pos_count[DIM_SLOW] = pos_count[DIM_SLOW] + 1'b1;
                else
                    pos_count[DIM_SLOW] = '0;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // register write over the cfg channel, mirrored into the predictor
    task automatic write_reg(t_cfg_reg which, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (which)
            REG_EXTENT_SLOW:  extent_reg[DIM_SLOW] = data;
            REG_EXTENT_MID:   extent_reg[DIM_MID]  = data;
            REG_EXTENT_FAST:  extent_reg[DIM_FAST] = data;
            REG_SOURCE_ORDER: src_order_reg = data[ORDER_W-1:0];
            REG_DEST_ORDER:   dst_order_reg = data[ORDER_W-1:0];
            REG_FLIP_X:       flip_reg[AXIS_X] = data[0];
            REG_FLIP_Y:       flip_reg[AXIS_Y] = data[0];
            REG_FLIP_Z:       flip_reg[AXIS_Z] = data[0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic set_extents(int unsigned slow, int unsigned mid, int unsigned fast);
        write_reg(REG_EXTENT_SLOW, EXT_W'(slow));
        write_reg(REG_EXTENT_MID, EXT_W'(mid));
        write_reg(REG_EXTENT_FAST, EXT_W'(fast));
    endtask

    task automatic set_mapping(logic [ORDER_W-1:0] src, logic [ORDER_W-1:0] dst,
                               logic fx, logic fy, logic fz);
        write_reg(REG_SOURCE_ORDER, CFG_DATA_W'(src));
        write_reg(REG_DEST_ORDER, CFG_DATA_W'(dst));
        write_reg(REG_FLIP_X, CFG_DATA_W'(fx));
        write_reg(REG_FLIP_Y, CFG_DATA_W'(fy));
        write_reg(REG_FLIP_Z, CFG_DATA_W'(fz));
    endtask

    // one request on s_axis; valid stays up when the next one follows at once
    task automatic offer_sample(logic [SAMPLE_BITS-1:0] sample);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge clk); while (!s_tready);
        pending_scatter.push_back(place_element(sample));
        samples_sent++;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            tx_held = 1'b0;
            repeat (gap) @(posedge clk);
        end else begin
            tx_held = 1'b1;
        end
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic wait_for_results();
        if (tx_held) begin
            s_tvalid <= 1'b0;
            tx_held = 1'b0;
            @(posedge clk);
        end
        while (pending_scatter.size() != 0)
            @(posedge clk);
    endtask

    // bring the counters back to the start of a volume: with all extents at
    // one every counter sits at its end, so one request wraps them all
    task automatic restart_volume();
        wait_for_results();
        if (pos_count[DIM_SLOW] != 0 || pos_count[DIM_MID] != 0 || pos_count[DIM_FAST] != 0) begin
            set_extents(1, 1, 1);
            offer_sample($urandom());
            wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------
    // receiver and result checking
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (hold_left > 0) begin
            rx_ready <= 1'b0;
            hold_left--;
        end else if (steady) begin
            rx_ready <= 1'b1;
        end else if (stall_left > 0) begin
            rx_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_ready <= 1'b0;
            stall_left = idle_len();
        end else begin
            rx_ready <= 1'b1;
        end
    end

    task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                     what, results_checked, want, got);
    endtask

    always @(posedge clk) begin : check_results
        t_scatter want;
        if (rst_n && m_tvalid && rx_ready) begin
            results_checked++;
            if (m_tlast)
                volume_ends++;
            if (pending_scatter.size() == 0) begin
                note_mismatch("unrequested result", 0, m_tdata);
            end else begin
                want = pending_scatter.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.index)
                    note_mismatch("dest_index", want.index, m_tdata[IDX_W-1:0]);
                if (m_tdata[IDX_W +: SAMPLE_BITS] !== want.value)
                    note_mismatch("moved_value", want.value, m_tdata[IDX_W +: SAMPLE_BITS]);
                if (m_tlast !== want.last)
                    note_mismatch("volume_end", want.last, m_tlast);
                if (m_tdata[OUT_TDATA_W-1:IDX_W+SAMPLE_BITS] !== '0)
                    note_mismatch("tdata fill", 0, m_tdata[OUT_TDATA_W-1:IDX_W+SAMPLE_BITS]);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers at reset: each sample is a whole one-element volume
    task automatic test_reset_state();
        offer_sample('0);
        offer_sample('1);
        offer_sample(32'hAAAA_AAAA);
        offer_sample(32'h5555_5555);
        wait_for_results();
    endtask

    // zero extent reads as one, oversize saturates, spare order codes act as
    // xyz, and only the low bits of each written word land in the register
    task automatic test_register_masking();
        write_reg(REG_EXTENT_SLOW, '0);
        write_reg(REG_EXTENT_MID, 11'h7FF);
        write_reg(REG_EXTENT_FAST, 11'd1030);
        write_reg(REG_SOURCE_ORDER, 11'h7F6);
        write_reg(REG_DEST_ORDER, 11'h7FF);
        write_reg(REG_FLIP_X, 11'h7FE);
        write_reg(REG_FLIP_Y, 11'h001);
        write_reg(REG_FLIP_Z, 11'h7FF);
        repeat (3) offer_sample($urandom());
        wait_for_results();
    endtask

    // each axis order once as source, paired with a different destination order
    task automatic test_axis_orders();
        restart_volume();
        set_extents(2, 3, 4);
        for (int s = ORDER_XYZ; s <= ORDER_ZYX; s++) begin
            wait_for_results();
            set_mapping(ORDER_W'(s), ORDER_W'(ORDER_ZYX - s), s[0], s[1], s[2]);
            offer_sample($urandom());
        end
        wait_for_results();
    endtask

    // largest volume with every axis reversed: first element lands on the top index
    task automatic test_full_extent();
        restart_volume();
        set_extents(MAX_EXTENT, MAX_EXTENT, MAX_EXTENT);
        set_mapping(ORDER_ZYX, ORDER_XYZ, 1'b1, 1'b1, 1'b1);
        repeat (2) offer_sample($urandom());
        wait_for_results();
    endtask

    // extents shrunk mid volume leave the counters past their ends
    task automatic test_counter_overrun();
        restart_volume();
        set_extents(3, 3, 3);
        set_mapping(ORDER_YZX, ORDER_ZXY, 1'b0, 1'b1, 1'b0);
        repeat (8) offer_sample($urandom());
        wait_for_results();
        set_extents(1, 2, 2);
        repeat (3) offer_sample($urandom());
        wait_for_results();
    endtask

    // receiver holds off while the sender keeps offering, so the pipe fills
    // and s_axis tready drops; then it drains, and two more bursts each end in a full drain
    task automatic test_backpressure();
        restart_volume();
        set_extents(4, 4, 4);
        set_mapping(ORDER_ZXY, ORDER_YXZ, 1'b1, 1'b0, 1'b1);
        steady = 1'b1;
        hold_left = 150;
        repeat (24) offer_sample($urandom());
        steady = 1'b0;
        wait_for_results();
        repeat (10) offer_sample($urandom());
        wait_for_results();
        repeat (10) offer_sample($urandom());
        wait_for_results();
    endtask

    // mostly small, with zero, saturating and large values now and then
    function automatic logic [EXT_W-1:0] random_extent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return EXT_W'($urandom_range(1, 5));
        if (r < 84)
            return EXT_W'($urandom_range(6, 12));
        if (r < 89)
            return '0;
        if (r < 94)
            return EXT_W'($urandom_range(MAX_EXTENT, 2047));
        return EXT_W'($urandom_range(13, MAX_EXTENT - 1));
    endfunction

    // a legal code most of the time, otherwise a raw word with spare codes
    function automatic logic [CFG_DATA_W-1:0] random_order();
        if ($urandom_range(0, 99) < 85)
            return CFG_DATA_W'($urandom_range(ORDER_XYZ, ORDER_ZYX));
        return CFG_DATA_W'($urandom());
    endfunction

    // mostly whole volumes from a clean start under a fresh setting; the rest
    // are partial runs with only some registers changed, often mid volume
    task automatic test_random_volumes(int target);
        int              n;
        longint unsigned vol;
        bit              whole;
        while (samples_sent < target) begin
            whole = ($urandom_range(0, 3) != 0);
            if (whole)
                restart_volume();
            else
                wait_for_results();
            steady = ($urandom_range(0, 5) == 0);
            if (whole || $urandom_range(0, 1)) begin
                write_reg(REG_EXTENT_SLOW, random_extent());
                write_reg(REG_EXTENT_MID, random_extent());
                write_reg(REG_EXTENT_FAST, random_extent());
            end
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_SOURCE_ORDER, random_order());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_DEST_ORDER, random_order());
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_FLIP_X, CFG_DATA_W'($urandom()));
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_FLIP_Y, CFG_DATA_W'($urandom()));
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_FLIP_Z, CFG_DATA_W'($urandom()));
            vol = longint'(effective_extent(extent_reg[DIM_SLOW]))
                * effective_extent(extent_reg[DIM_MID])
                * effective_extent(extent_reg[DIM_FAST]);
            if (whole && vol <= 96)
                n = int'(vol * $urandom_range(1, 3));
            else
                n = $urandom_range(1, 40);
            repeat (n) offer_sample($urandom());
        end
        wait_for_results();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_masking();
        test_axis_orders();
        test_full_extent();
        test_counter_overrun();
        test_backpressure();
        test_random_volumes(samples_sent + RANDOM_SAMPLES);

        // let any stray result show up before judging
        wait_for_results();
        repeat (16) @(posedge clk);

        $display("run: %0d samples, %0d results checked, %0d volume ends, %0d register writes",
                 samples_sent, results_checked, volume_ends, cfg_writes);
        $display("run: all axis orders both ways, flips, extent zero and saturation,",
                 " shrunk extents mid volume, long output hold-off");
        if (mismatches == 0 && pending_scatter.size() == 0) begin
            $display("volume_axis_permute_flip_core test passed");
        end else begin
            $display("volume_axis_permute_flip_core test failed");
        end
        $finish;
    end

endmodule
